[rtl/core/vcs_pkg.sv]
// vcs_pkg: widths, constants and controller/datapath interface types
// for the vector cosine similarity block
// no dependencies
package vcs_pkg;

    localparam int ELEM_W   = 16;                  // element and result width
    localparam int EPROD_W  = 2 * ELEM_W;          // element product width
    localparam int ACC_W    = 48;                  // accumulator width
    localparam int HALF_W   = ACC_W / 2;           // operand half for the shared multiplier
    localparam int PP_W     = 2 * HALF_W;          // partial product width
    localparam int PROD_W   = 2 * ACC_W;           // sum_a * sum_b width
    localparam int NUM_SH   = 2 * (ELEM_W - 1);    // scale of the squared dot product
    localparam int ROOT_W   = 130;                 // width of the root search words
    localparam int Q_W      = ELEM_W;              // quotient magnitude width
    localparam int CNT_W    = 4;                   // sequencer step counter
    localparam int MUL_LAST = 7;                   // last partial product index
    localparam int ROOT_LAST = Q_W - 1;            // last quotient bit step

    // commands from controller to datapath
    typedef struct packed {
        logic       acc_en;      // element transaction accepted
        logic       last_en;     // element transaction carries the last flag
        logic       mul_en;      // issue one partial product
        logic [2:0] mul_idx;     // which partial product
        logic       root_add;    // root step, first half: sum of square terms
        logic       root_cmp;    // root step, second half: trial compare
        logic       root_first;  // first quotient bit (value 32768)
        logic       out_load;    // load the result register
    } vcs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic zero_norm;         // either final sum of squares is zero
    } vcs_stat_t;

endpackage

[rtl/core/vcs_ctrl.sv]
// vcs_ctrl: sequencer for the cosine similarity block
// depends on vcs_pkg (command and status types, step counts)
module vcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_element,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  vcs_pkg::vcs_stat_t   stat,
    output vcs_pkg::vcs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_DRAIN,
        ST_ROOT_ADD,
        ST_ROOT_CMP,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [vcs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       in_take;
    logic                       skip_mul;
    logic                       out_free;

    assign in_ready  = (state_reg == ST_ACCUM);
    assign out_valid = out_valid_reg;
    assign in_take   = in_valid && (state_reg == ST_ACCUM);
    assign skip_mul  = (cnt_reg == '0) && stat.zero_norm;
    assign out_free  = !out_valid_reg || out_ready;

    // commands decoded from state
    always_comb
    begin
        cmd            = '0;
        cmd.acc_en     = in_take;
        cmd.last_en    = in_take && last_element;
        cmd.mul_en     = (state_reg == ST_MUL) && !skip_mul;
        cmd.mul_idx    = cnt_reg[2:0];
        cmd.root_add   = (state_reg == ST_ROOT_ADD);
        cmd.root_cmp   = (state_reg == ST_ROOT_CMP);
        cmd.root_first = (cnt_reg == '0);
        cmd.out_load   = (state_reg == ST_DONE) && out_free;
    end

    // next state and counter
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (in_take && last_element)
                begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL:
            begin
                if (skip_mul)
                begin
                    state_next = ST_DONE;
                end
                else if (cnt_reg == vcs_pkg::CNT_W'(vcs_pkg::MUL_LAST))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ROOT_ADD;
                cnt_next   = '0;
            end
            ST_ROOT_ADD:
            begin
                state_next = ST_ROOT_CMP;
            end
            ST_ROOT_CMP:
            begin
                if (cnt_reg == vcs_pkg::CNT_W'(vcs_pkg::ROOT_LAST))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ROOT_ADD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/vcs_dpath.sv]
// vcs_dpath: accumulators, shared 24x24 multiplier and bitwise root/divide search
// depends on vcs_pkg (widths, command and status types)
module vcs_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vcs_pkg::vcs_cmd_t                   cmd,
    output vcs_pkg::vcs_stat_t                  stat,
    input  logic signed [vcs_pkg::ELEM_W-1:0]   a_element,
    input  logic signed [vcs_pkg::ELEM_W-1:0]   b_element,
    output logic signed [vcs_pkg::ELEM_W-1:0]   similarity,
    output logic                                zero_norm
);

    localparam int AW = vcs_pkg::ACC_W;
    localparam int HW = vcs_pkg::HALF_W;
    localparam int RW = vcs_pkg::ROOT_W;
    localparam int QW = vcs_pkg::Q_W;

    // running accumulators
    logic signed [AW-1:0]  dot_reg;
    logic [AW-1:0]         sqa_reg, sqb_reg;
    logic signed [vcs_pkg::EPROD_W-1:0] p_ab, p_aa, p_bb;
    logic signed [AW:0]    dot_sum;
    logic [AW:0]           sqa_sum, sqb_sum;
    logic signed [AW-1:0]  dot_next;
    logic [AW-1:0]         sqa_next, sqb_next;

    // values frozen at the last element
    logic [AW-1:0]         fin_sa_reg, fin_sb_reg, mag_reg;
    logic                  neg_reg, zero_reg;
    logic [AW-1:0]         mag_next;

    // shared multiplier
    logic [HW-1:0]                mul_a, mul_b;
    logic [vcs_pkg::PP_W-1:0]     pp_reg;
    logic [2:0]                   pp_idx_reg;
    logic                         pp_vld_reg;
    logic [RW-1:0]                pp_sh;
    logic [vcs_pkg::PROD_W-1:0]   prod_reg;
    logic [RW-1:0]                num_reg;

    // root search
    logic [RW-1:0]   p_reg, s_reg, t_reg, p2k_reg;
    logic [RW-1:0]   t2;
    logic            take;
    logic [QW-1:0]   q_reg;
    logic            cap_reg;
    logic signed [QW:0] sim_w;

    // output register
    logic signed [vcs_pkg::ELEM_W-1:0] sim_reg;
    logic                              zn_reg;

    // element products and saturating sums
    assign p_ab    = a_element * b_element;
    assign p_aa    = a_element * a_element;
    assign p_bb    = b_element * b_element;
    assign dot_sum = {dot_reg[AW-1], dot_reg} + (AW+1)'(p_ab);
    assign sqa_sum = {1'b0, sqa_reg} + (AW+1)'(unsigned'(p_aa));
    assign sqb_sum = {1'b0, sqb_reg} + (AW+1)'(unsigned'(p_bb));

    always_comb
    begin
        if (dot_sum[AW] != dot_sum[AW-1])
        begin
            dot_next = dot_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        else
        begin
            dot_next = dot_sum[AW-1:0];
        end
        sqa_next = sqa_sum[AW] ? {AW{1'b1}} : sqa_sum[AW-1:0];
        sqb_next = sqb_sum[AW] ? {AW{1'b1}} : sqb_sum[AW-1:0];
        mag_next = dot_next[AW-1] ? (~dot_next + 1'b1) : dot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
        end
        else if (cmd.last_en)
        begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            dot_reg <= dot_next;
            sqa_reg <= sqa_next;
            sqb_reg <= sqb_next;
        end
    end

    // freeze the final sums for the division
    always_ff @(posedge clk)
    begin
        if (cmd.last_en)
        begin
            fin_sa_reg <= sqa_next;
            fin_sb_reg <= sqb_next;
            mag_reg    <= mag_next;
            neg_reg    <= dot_next[AW-1];
            zero_reg   <= (sqa_next == '0) || (sqb_next == '0);
        end
    end

    assign stat.zero_norm = zero_reg;

    // operand select: indexes 0..3 build sum_a*sum_b, 4..7 build dot^2
    always_comb
    begin
        if (cmd.mul_idx[2])
        begin
            mul_a = cmd.mul_idx[1] ? mag_reg[AW-1:HW] : mag_reg[HW-1:0];
            mul_b = cmd.mul_idx[0] ? mag_reg[AW-1:HW] : mag_reg[HW-1:0];
        end
        else
        begin
            mul_a = cmd.mul_idx[1] ? fin_sa_reg[AW-1:HW] : fin_sa_reg[HW-1:0];
            mul_b = cmd.mul_idx[0] ? fin_sb_reg[AW-1:HW] : fin_sb_reg[HW-1:0];
        end
    end

    // partial product alignment
    always_comb
    begin
        unique case ({1'b0, pp_idx_reg[1]} + {1'b0, pp_idx_reg[0]})
            2'd0:    pp_sh = RW'(pp_reg);
            2'd1:    pp_sh = RW'(pp_reg) << HW;
            2'd2:    pp_sh = RW'(pp_reg) << (2 * HW);
            default: pp_sh = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= cmd.mul_en;
        end
    end

    // multiply into pp_reg, then accumulate the registered partial product
    always_ff @(posedge clk)
    begin
        pp_reg     <= mul_a * mul_b;
        pp_idx_reg <= cmd.mul_idx;
        if (cmd.last_en)
        begin
            prod_reg <= '0;
            num_reg  <= '0;
        end
        else if (pp_vld_reg)
        begin
            if (pp_idx_reg[2])
            begin
                num_reg <= num_reg + (pp_sh << vcs_pkg::NUM_SH);
            end
            else
            begin
                prod_reg <= prod_reg + pp_sh[vcs_pkg::PROD_W-1:0];
            end
        end
    end

    // trial: prod*(q + 2^k)^2 = P + prod*q*2^(k+1) + prod*2^(2k)
    assign t2   = t_reg + p2k_reg;
    assign take = !cap_reg && (t2 <= num_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.root_add)
        begin
            if (cmd.root_first)
            begin
                t_reg   <= '0;
                p_reg   <= '0;
                s_reg   <= '0;
                q_reg   <= '0;
                cap_reg <= 1'b0;
                p2k_reg <= RW'({prod_reg, {vcs_pkg::NUM_SH{1'b0}}});
            end
            else
            begin
                t_reg <= p_reg + s_reg;
            end
        end
        else if (cmd.root_cmp)
        begin
            q_reg   <= {q_reg[QW-2:0], take};
            p2k_reg <= p2k_reg >> 2;
            if (take)
            begin
                p_reg <= t2;
                s_reg <= (s_reg >> 1) + p2k_reg;
            end
            else
            begin
                s_reg <= s_reg >> 1;
            end
            if (cmd.root_first && take)
            begin
                cap_reg <= 1'b1;
            end
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        sim_w = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            zn_reg <= zero_reg;
            if (zero_reg)
            begin
                sim_reg <= '0;
            end
            else if (!neg_reg && q_reg[QW-1])
            begin
                sim_reg <= {1'b0, {(QW-1){1'b1}}};
            end
            else
            begin
                sim_reg <= sim_w[QW-1:0];
            end
        end
    end

    assign similarity = sim_reg;
    assign zero_norm  = zn_reg;

endmodule

[rtl/core/vector_cosine_similarity.sv]
// vector_cosine_similarity: streaming cosine similarity of two Q1.15 vectors
// after the last pair the result is built from 8 partial products on the shared
// 24x24 multiplier, a drain state, 16 quotient bit steps (an add and a compare
// state each) and one load; a zero norm skips the products and the root steps
// throughput: one pair per cycle while accumulating, no pairs during the division
// reset: rst_n asynchronous active low, clears accumulators and control state
module vector_cosine_similarity (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vcs_pkg::ELEM_W-1:0]   a_element,
    input  logic signed [vcs_pkg::ELEM_W-1:0]   b_element,
    input  logic                                last_element,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vcs_pkg::ELEM_W-1:0]   similarity,
    output logic                                zero_norm
);

    vcs_pkg::vcs_cmd_t  cmd;
    vcs_pkg::vcs_stat_t stat;

    // sequencer
    vcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last_element (last_element),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // arithmetic
    vcs_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .a_element  (a_element),
        .b_element  (b_element),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

[sim/tb_vector_cosine_similarity.sv]
// tb_vector_cosine_similarity: self-checking testbench for the streaming cosine similarity block
// predicts each Q1.15 result from its own accumulators and exact root search
// depends on vcs_pkg and vector_cosine_similarity
module tb_vector_cosine_similarity;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEM_W         = vcs_pkg::ELEM_W;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;      // a little longer than a divide
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int WIDE_W         = 130;

    localparam longint          DOT_MAX    = 64'sd140737488355327;
    localparam longint          DOT_MIN    = -64'sd140737488355328;
    localparam longint unsigned SQUARE_MAX = 64'd281474976710655;

    typedef enum int
    {
        VEC_RANDOM,
        VEC_SAME,
        VEC_OPPOSITE,
        VEC_NOISY,
        VEC_SMALL,
        VEC_ZERO_A,
        VEC_ZERO_B,
        VEC_EXTREME
    } vec_kind_e;

    typedef struct packed
    {
        logic signed [ELEM_W-1:0] similarity;
        logic                     zero_norm;
    } cosine_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic signed [ELEM_W-1:0] a_element    = '0;
    logic signed [ELEM_W-1:0] b_element    = '0;
    logic                     last_element = 1'b0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic signed [ELEM_W-1:0] similarity;
    logic                     zero_norm;

    // predictor state
    longint          dot_acc   = 0;
    longint unsigned sum_sq_a  = 0;
    longint unsigned sum_sq_b  = 0;
    cosine_result_t  expected_results[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_request    = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int zero_norm_count = 0;
    int pairs_sent      = 0;
    int vectors_sent    = 0;
    int stall_cycles    = 0;

    vector_cosine_similarity DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .a_element    (a_element),
        .b_element    (b_element),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .similarity   (similarity),
        .zero_norm    (zero_norm)
    );

    // clock
    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    // exact truncated quotient: largest q <= 32768 with sa*sb*q*q <= (|dot|<<15)^2
    function automatic logic signed [ELEM_W-1:0] cosine_fraction(
        input longint dot, input longint unsigned sa, input longint unsigned sb);
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] prod;
        logic [WIDE_W-1:0] trial;
        logic [WIDE_W-1:0] m;
        longint unsigned   mag;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        int                q;
        mag  = (dot < 0) ? -dot : dot;
        num  = WIDE_W'(mag);
        num  = num << 15;
        num  = num * num;
        prod = WIDE_W'(sa);
        prod = prod * WIDE_W'(sb);
        lo   = 0;
        hi   = 32768;
        while (lo < hi)
        begin
            mid   = (lo + hi + 1) >> 1;
            m     = WIDE_W'(mid);
            trial = prod * m * m;
            if (trial <= num)
                lo = mid;
            else
                hi = mid - 1;
        end
        q = (dot < 0) ? -int'(lo) : int'(lo);
        if (q > 32767)
            q = 32767;
        return q[ELEM_W-1:0];
    endfunction

    // saturating accumulate of one pair, result queued on the last pair
    function automatic void accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                            input logic signed [ELEM_W-1:0] b,
                                            input logic last);
        longint         pa;
        longint         pb;
        longint         d;
        cosine_result_t r;
        pa = longint'(a);
        pb = longint'(b);
        d  = dot_acc + pa * pb;
        if (d > DOT_MAX)
            d = DOT_MAX;
        if (d < DOT_MIN)
            d = DOT_MIN;
        dot_acc  = d;
        sum_sq_a = sum_sq_a + pa * pa;
        sum_sq_b = sum_sq_b + pb * pb;
        if (sum_sq_a > SQUARE_MAX)
            sum_sq_a = SQUARE_MAX;
        if (sum_sq_b > SQUARE_MAX)
            sum_sq_b = SQUARE_MAX;
        if (last)
        begin
            if (sum_sq_a == 0 || sum_sq_b == 0)
            begin
                r.similarity = '0;
                r.zero_norm  = 1'b1;
            end
            else
            begin
                r.similarity = cosine_fraction(dot_acc, sum_sq_a, sum_sq_b);
                r.zero_norm  = 1'b0;
            end
            expected_results.push_back(r);
            dot_acc  = 0;
            sum_sq_a = 0;
            sum_sq_b = 0;
        end
    endfunction

    // one element pair transaction, with random idle before it
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        a_element    <= a;
        b_element    <= b;
        last_element <= last;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_pair(a, b, last);
        pairs_sent++;
        if (last)
            vectors_sent++;
    endtask

    // stop offering and let every expected result come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [ELEM_W-1:0] extreme_element();
        case ($urandom_range(4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    // one vector of the given shape, last flag on its final pair
    task automatic send_vector(input int len, input vec_kind_e kind);
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        int                       t;
        for (int i = 0; i < len; i++)
        begin
            a = ELEM_W'($urandom_range(65535));
            b = ELEM_W'($urandom_range(65535));
            case (kind)
                VEC_SAME:
                    b = a;
                VEC_OPPOSITE:
                    b = (a == -16'sd32768) ? 16'sd32767 : -a;
                VEC_NOISY:
                begin
                    t = int'(a) + int'($urandom_range(64)) - 32;
                    if (t > 32767)
                        t = 32767;
                    if (t < -32768)
                        t = -32768;
                    b = ELEM_W'(t);
                end
                VEC_SMALL:
                begin
                    a = ELEM_W'(int'($urandom_range(15)) - 8);
                    b = ELEM_W'(int'($urandom_range(15)) - 8);
                end
                VEC_ZERO_A:
                    a = '0;
                VEC_ZERO_B:
                    b = '0;
                VEC_EXTREME:
                begin
                    a = extreme_element();
                    b = extreme_element();
                end
                default:
                    ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // extremes, exact parallel and opposite, zero norms, orthogonal pairs
    task automatic test_directed_extremes();
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(-16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd0, 16'sd100, 1'b0);
        send_pair(16'sd0, -16'sd5, 1'b1);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd12345, -16'sd3210, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, 1'b0);
        send_pair(16'sd20000, 16'sd20001, 1'b1);
        send_pair(16'sd32767, 16'sd1, 1'b0);
        send_pair(16'sd1, 16'sd32767, 1'b1);
        wait_idle();
    endtask

    // random vectors, mostly short, weighted toward correlated shapes
    task automatic test_random_vectors(input int n_pairs);
        int        start;
        int        len;
        int        pick;
        vec_kind_e kind;
        start = pairs_sent;
        while (pairs_sent - start < n_pairs)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 95)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 200);
            pick = $urandom_range(99);
            if (pick < 30)
                kind = VEC_RANDOM;
            else if (pick < 42)
                kind = VEC_SAME;
            else if (pick < 54)
                kind = VEC_OPPOSITE;
            else if (pick < 66)
                kind = VEC_NOISY;
            else if (pick < 76)
                kind = VEC_SMALL;
            else if (pick < 82)
                kind = VEC_ZERO_A;
            else if (pick < 88)
                kind = VEC_ZERO_B;
            else
                kind = VEC_EXTREME;
            send_vector(len, kind);
        end
        wait_idle();
    endtask

    // receiver stalls for a long stretch while short vectors keep coming
    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 10; i++)
            send_vector($urandom_range(1, 3), VEC_RANDOM);
        wait_idle();
    endtask

    // receiver ready, with random stalls and a counted hold-off
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        cosine_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got similarity %0d zero_norm %0b",
                             $realtime, similarity, zero_norm);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.zero_norm)
                    zero_norm_count++;
                if (similarity !== want.similarity || zero_norm !== want.zero_norm)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: result %0d expected similarity %0d zero_norm %0b, got %0d %0b",
                                 $realtime, results_checked, want.similarity, want.zero_norm,
                                 similarity, zero_norm);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $realtime, stall_cycles, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // test sequence
    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 72;
        test_directed_extremes();
        test_random_vectors(600);
        test_output_backpressure();

        send_idle_pct = 72;
        recv_idle_pct = 19;
        test_random_vectors(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_vectors(650);

        mismatch_count += expected_results.size();
        $display("sent %0d element pairs in %0d vectors, checked %0d results (%0d zero norm)",
                 pairs_sent, vectors_sent, results_checked, zero_norm_count);
        $display("covered field extremes, parallel and opposite vectors, output stalls, quotient saturation");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[vector_cosine_similarity.f]
rtl/core/vcs_pkg.sv
rtl/core/vcs_ctrl.sv
rtl/core/vcs_dpath.sv
rtl/core/vector_cosine_similarity.sv
sim/tb_vector_cosine_similarity.sv
